[src/rtli_pkg.sv]
`timescale 1ns / 1ps

package rtli_pkg;

  // Default tree geometry.
  localparam int LEVEL_BITS_DEF  = 4;
  localparam int POOL_NODES_DEF  = 256;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the ports.
  localparam int KEY_BITS_W  = 6;
  localparam int OUT_VALUE_W = 32;
  localparam int STATUS_W    = 2;

  localparam logic [KEY_BITS_W-1:0] KEY_BITS_RST = KEY_BITS_W'(32);

  typedef enum logic [STATUS_W-1:0] {
    RS_FOUND     = 2'd0,
    RS_INSERTED  = 2'd1,
    RS_ABSENT    = 2'd2,
    RS_EXHAUSTED = 2'd3
  } status_t;

  // Sequencer steps; each one is an address of the control store.
  typedef enum logic [1:0] {
    S_CLR  = 2'd0,
    S_IDLE = 2'd1,
    S_DIR  = 2'd2,
    S_VAL  = 2'd3
  } step_t;

  // What a step waits for before it executes.
  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_OUT  = 2'd2
  } hold_t;

  // Branch condition that picks between the two targets.
  typedef enum logic [1:0] {
    C_ALWAYS     = 2'd0,
    C_CLR_DONE   = 2'd1,
    C_DEPTH_ZERO = 2'd2,
    C_LAST_LVL   = 2'd3
  } cond_t;

  typedef struct packed {
    logic  clr_en;
    logic  take_in;
    logic  dir_eval;
    logic  val_eval;
    hold_t hold;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // The control store. A step that produces a result returns to S_IDLE
  // regardless of its targets.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    w.hold  = HOLD_NONE;
    w.cond  = C_ALWAYS;
    w.tgt_t = S_IDLE;
    w.tgt_f = S_IDLE;
    case (s)
      S_CLR: begin
        w.clr_en = 1'b1;
        w.cond   = C_CLR_DONE;
        w.tgt_t  = S_IDLE;
        w.tgt_f  = S_CLR;
      end
      S_IDLE: begin
        w.take_in = 1'b1;
        w.hold    = HOLD_IN;
        w.cond    = C_DEPTH_ZERO;
        w.tgt_t   = S_VAL;
        w.tgt_f   = S_DIR;
      end
      S_DIR: begin
        w.dir_eval = 1'b1;
        w.hold     = HOLD_OUT;
        w.cond     = C_LAST_LVL;
        w.tgt_t    = S_VAL;
        w.tgt_f    = S_DIR;
      end
      S_VAL: begin
        w.val_eval = 1'b1;
        w.hold     = HOLD_OUT;
      end
      default: begin
        w.tgt_t = S_IDLE;
        w.tgt_f = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[src/rtli_ifs.sv]
`timescale 1ns / 1ps

interface rtli_req_if #(
  parameter int KEY_WIDTH   = rtli_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = rtli_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [KEY_WIDTH-1:0]   key;
  logic                   create_request;
  logic [VALUE_WIDTH-1:0] new_value;

  modport source (output valid, key, create_request, new_value, input ready);
  modport sink   (input valid, key, create_request, new_value, output ready);
endinterface

interface rtli_rsp_if;
  import rtli_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] value;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface rtli_cfg_if;
  import rtli_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS_W-1:0] key_bits;

  modport source (output valid, key_bits, input ready);
  modport sink   (input valid, key_bits, output ready);
endinterface

[src/radix_tree_lookup_insert.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Item contents
// in_req    in   valid/ready    key, create_request, new_value
// out_rsp   out  valid/ready    value, status
// cfg_wr    in   valid/ready    key_bits (tree depth control)
//
// An item is taken in the idle step, then walks one directory step per level, D = ceil(key_bits /
// LEVEL_BITS), and ends in one value step; the next item is taken only after that, and the
// single read port of the node pool sets this order. An early miss ends the walk sooner.
// After reset a clearing pass zeroes all POOL_NODES * 2^LEVEL_BITS slots before the first item
// is taken. While a result waits in the output register, the sequencer stalls at its next
// directory or value step until the consumer takes it.

module radix_tree_lookup_insert #(
  parameter int LEVEL_BITS  = rtli_pkg::LEVEL_BITS_DEF,
  parameter int POOL_NODES  = rtli_pkg::POOL_NODES_DEF,
  parameter int KEY_WIDTH   = rtli_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = rtli_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rtli_req_if.sink   in_req,
  rtli_rsp_if.source out_rsp,
  rtli_cfg_if.sink   cfg_wr
);
  import rtli_pkg::*;

  // Pool geometry. A slot holds either a node index or a stored value, so
  // it is as wide as the wider of the two.
  localparam int SLOTS      = 1 << LEVEL_BITS;
  localparam int POOL_SLOTS = POOL_NODES * SLOTS;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int ADDR_W     = NODE_W + LEVEL_BITS;
  localparam int CNT_W      = $clog2(POOL_NODES + 1);
  localparam int SLOT_W     = (VALUE_WIDTH > NODE_W) ? VALUE_WIDTH : NODE_W;
  localparam int KB_MAX     = (1 << KEY_BITS_W) - 1;
  localparam int DEPTH_MAX  = (KB_MAX + LEVEL_BITS - 1) / LEVEL_BITS;
  localparam int LVL_W      = $clog2(DEPTH_MAX + 1);
  localparam int SHIFT_W    = $clog2(DEPTH_MAX * LEVEL_BITS + 1);

  // Control registers.
  step_t                  step_r, step_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [KEY_BITS_W-1:0]  key_bits_r, key_bits_nxt;
  logic [SLOT_W-1:0]      root_r, root_nxt;
  logic [CNT_W-1:0]       next_free_r, next_free_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Per-item working registers.
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic                   create_r, create_nxt;
  logic [VALUE_WIDTH-1:0] new_value_r, new_value_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic                   at_root_r, at_root_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                out_status_r, out_status_nxt;

  // Node pool memory with one write and one registered read port.
  logic [SLOT_W-1:0]      pool_mem [POOL_SLOTS];
  logic [SLOT_W-1:0]      rdata_r;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SLOT_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;

  ucode_t                 uc;
  logic                   exec;
  logic                   cond_true;
  logic                   emit;
  logic                   out_free;
  logic [LVL_W-1:0]       depth_c;
  logic [SHIFT_W-1:0]     shift0_c;
  logic [SLOT_W-1:0]      cur_slot;
  logic                   slot_empty;
  logic                   pool_full;
  logic [LEVEL_BITS-1:0]  slice_c;
  logic [NODE_W-1:0]      node_sel;

  assign uc = ucode_rom(step_r);

  // Tree depth and the shift of the top slice follow from key_bits. The
  // compares are independent; the last one that holds wins.
  always_comb begin
    depth_c  = '0;
    shift0_c = '0;
    for (int d = 0; d < DEPTH_MAX; d++) begin
      if (int'(key_bits_r) > d * LEVEL_BITS) begin
        depth_c  = LVL_W'(d + 1);
        shift0_c = SHIFT_W'(d * LEVEL_BITS);
      end
    end
  end

  // The slot under examination is the root register before the first
  // level and the registered memory read after it. A link that points
  // outside the pool counts as an empty directory slot.
  assign cur_slot   = at_root_r ? root_r : rdata_r;
  assign slot_empty = (cur_slot == '0) ||
                      ({1'b0, cur_slot} >= (SLOT_W + 1)'(POOL_NODES));
  assign pool_full  = (next_free_r == CNT_W'(POOL_NODES));
  assign slice_c    = LEVEL_BITS'(key_r >> shift_r);
  assign node_sel   = slot_empty ? NODE_W'(next_free_r) : NODE_W'(cur_slot);

  // A step that may produce a result waits until the output register is
  // free, so nothing is written to the pool while it waits.
  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    case (uc.hold)
      HOLD_IN:  exec = in_req.valid;
      HOLD_OUT: exec = out_free;
      default:  exec = 1'b1;
    endcase
  end

  always_comb begin
    case (uc.cond)
      C_CLR_DONE:   cond_true = (clr_addr_r == ADDR_W'(POOL_SLOTS - 1));
      C_DEPTH_ZERO: cond_true = (depth_c == '0);
      C_LAST_LVL:   cond_true = (lvl_r == LVL_W'(1));
      default:      cond_true = 1'b1;
    endcase
  end

  // Datapath and sequencer next-state logic.
  always_comb begin
    step_nxt       = step_r;
    clr_addr_nxt   = clr_addr_r;
    key_bits_nxt   = key_bits_r;
    root_nxt       = root_r;
    next_free_nxt  = next_free_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    key_nxt        = key_r;
    create_nxt     = create_r;
    new_value_nxt  = new_value_r;
    lvl_nxt        = lvl_r;
    shift_nxt      = shift_r;
    at_root_nxt    = at_root_r;
    pos_nxt        = pos_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = pos_r;
    emit           = 1'b0;

    if (cfg_wr.valid) begin
      key_bits_nxt = cfg_wr.key_bits;
    end

    if (uc.clr_en) begin
      mem_we       = 1'b1;
      mem_waddr    = clr_addr_r;
      mem_wdata    = '0;
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
    end

    if (uc.take_in && exec) begin
      key_nxt       = in_req.key;
      create_nxt    = in_req.create_request;
      new_value_nxt = in_req.new_value;
      lvl_nxt       = depth_c;
      shift_nxt     = shift0_c;
      at_root_nxt   = 1'b1;
    end

    // One directory level: follow the link, or allocate a node when the
    // slot is empty and creation is asked for. The read of the next level
    // is issued in the same cycle, at an address inside the node just
    // chosen. A stale value read as a link can make that the very slot
    // being written; the memory then forwards the new link to the read.
    if (uc.dir_eval && exec) begin
      if (slot_empty && !create_r) begin
        emit           = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = RS_ABSENT;
      end else if (slot_empty && pool_full) begin
        emit           = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = RS_EXHAUSTED;
      end else begin
        if (slot_empty) begin
          next_free_nxt = next_free_r + CNT_W'(1);
          if (at_root_r) begin
            root_nxt = SLOT_W'(next_free_r);
          end else begin
            mem_we    = 1'b1;
            mem_wdata = SLOT_W'(next_free_r);
          end
        end
        pos_nxt     = {node_sel, slice_c};
        mem_re      = 1'b1;
        mem_raddr   = {node_sel, slice_c};
        at_root_nxt = 1'b0;
        lvl_nxt     = lvl_r - LVL_W'(1);
        shift_nxt   = shift_r - SHIFT_W'(LEVEL_BITS);
      end
    end

    // The value slot: report a stored value, store the new one, or report it absent.
    if (uc.val_eval && exec) begin
      emit = 1'b1;
      if (cur_slot != '0) begin
        out_value_nxt  = OUT_VALUE_W'(cur_slot);
        out_status_nxt = RS_FOUND;
      end else if (!create_r || (new_value_r == '0)) begin
        out_value_nxt  = '0;
        out_status_nxt = RS_ABSENT;
      end else begin
        if (at_root_r) begin
          root_nxt = SLOT_W'(new_value_r);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = SLOT_W'(new_value_r);
        end
        out_value_nxt  = OUT_VALUE_W'(new_value_r);
        out_status_nxt = RS_INSERTED;
      end
    end

    if (exec) begin
      step_nxt = cond_true ? uc.tgt_t : uc.tgt_f;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      step_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      if (mem_we && (mem_waddr == mem_raddr)) begin
        rdata_r <= mem_wdata;
      end else begin
        rdata_r <= pool_mem[mem_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_CLR;
      clr_addr_r  <= '0;
      key_bits_r  <= KEY_BITS_RST;
      root_r      <= '0;
      next_free_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      clr_addr_r  <= clr_addr_nxt;
      key_bits_r  <= key_bits_nxt;
      root_r      <= root_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    create_r     <= create_nxt;
    new_value_r  <= new_value_nxt;
    lvl_r        <= lvl_nxt;
    shift_r      <= shift_nxt;
    at_root_r    <= at_root_nxt;
    pos_r        <= pos_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_req.ready   = uc.take_in;
  assign cfg_wr.ready   = 1'b1;
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.value  = out_value_r;
  assign out_rsp.status = out_status_r;

  // The allocator never runs past the end of the pool.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= CNT_W'(POOL_NODES))
    else $error("node allocator ran past the pool");

  // The allocator only moves forward, one node at a time.
  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r == $past(next_free_r)) ||
    (next_free_r == $past(next_free_r) + CNT_W'(1)))
    else $error("node allocator moved by more than one");

  // A new result only comes out of a directory or value step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == S_DIR || $past(step_r) == S_VAL))
    else $error("result produced outside a lookup step");

  // An insertion never reports an empty value.
  a_ins_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == RS_INSERTED) |-> (out_value_r != '0))
    else $error("inserted result with zero value");

endmodule
